FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RASF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rasf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RASF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rasf assertion failed");

`endif

FILE: rtl/rasf_pkg.sv
// Types and constants of the relay-agent suboption finder.
package rasf_pkg;

	localparam logic [7:0] REMOTE_ID_CODE = 8'd2;
	localparam logic [7:0] WANTED_CODE_RESET = 8'd2;
	localparam int ValueW = 48;

	typedef enum logic [2:0] {
		ST_FOUND          = 3'd0,
		ST_NOT_FOUND      = 3'd1,
		ST_MISSING_LENGTH = 3'd2,
		ST_TOO_LONG       = 3'd3,
		ST_TRUNCATED      = 3'd4
	} status_t;

	typedef enum logic [5:0] {
		PH_CODE     = 6'b000001,
		PH_LEN_MISS = 6'b000010,
		PH_LEN_HIT  = 6'b000100,
		PH_SKIP     = 6'b001000,
		PH_CAPTURE  = 6'b010000,
		PH_DONE     = 6'b100000
	} phase_t;

	typedef struct packed {
		logic              emit;
		status_t           status;
		logic [ValueW-1:0] value_bytes;
		logic [2:0]        value_length;
	} result_t;

endpackage

FILE: rtl/rasf_step.sv
// Per-byte state update and result decision of the suboption finder.
module rasf_step import rasf_pkg::*; #(
	parameter int MAX_VALUE_BYTES = 6,
	localparam int CntW = $clog2(MAX_VALUE_BYTES + 1)
) (
	input  phase_t            phase,
	input  logic [7:0]        bytes_left,
	input  logic [ValueW-1:0] captured,
	input  logic [CntW-1:0]   cnt,
	input  logic [7:0]        wanted_code,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output phase_t            phase_nxt,
	output logic [7:0]        bytes_left_nxt,
	output logic [ValueW-1:0] captured_nxt,
	output logic [CntW-1:0]   cnt_nxt,
	output result_t           res
);

	logic [7:0]        left_dec;
	logic [ValueW-1:0] cap_shift;
	logic [CntW-1:0]   cnt_inc;
	logic              emit;
	status_t           emit_st;
	logic [ValueW-1:0] emit_val;
	logic [CntW-1:0]   emit_cnt;

	always_comb begin
		left_dec       = bytes_left - 8'd1;
		cap_shift      = {captured[ValueW-9:0], data_byte};
		cnt_inc        = cnt + CntW'(1);
		phase_nxt      = phase;
		bytes_left_nxt = bytes_left;
		captured_nxt   = captured;
		cnt_nxt        = cnt;
		emit           = 1'b0;
		emit_st        = ST_FOUND;
		emit_val       = '0;
		emit_cnt       = '0;

		unique case (phase)
			PH_CODE: begin
				if (last_byte) begin
					emit    = 1'b1;
					emit_st = ST_MISSING_LENGTH;
				end else begin
					phase_nxt = (data_byte == wanted_code) ? PH_LEN_HIT : PH_LEN_MISS;
				end
			end
			PH_LEN_HIT: begin
				if (wanted_code != REMOTE_ID_CODE) begin
					emit    = 1'b1;
					emit_st = ST_FOUND;
				end else if (data_byte > 8'(MAX_VALUE_BYTES)) begin
					emit    = 1'b1;
					emit_st = ST_TOO_LONG;
				end else if (data_byte == 8'd0 || last_byte) begin
					// Nothing has been captured yet, so the value fields stay zero.
					emit    = 1'b1;
					emit_st = (data_byte == 8'd0) ? ST_FOUND : ST_TRUNCATED;
					emit_val = captured;
					emit_cnt = cnt;
				end else begin
					captured_nxt   = '0;
					cnt_nxt        = '0;
					bytes_left_nxt = data_byte;
					phase_nxt      = PH_CAPTURE;
				end
			end
			PH_LEN_MISS: begin
				if (data_byte == 8'd0) begin
					if (last_byte) begin
						emit    = 1'b1;
						emit_st = ST_NOT_FOUND;
					end else begin
						phase_nxt = PH_CODE;
					end
				end else if (last_byte) begin
					emit    = 1'b1;
					emit_st = ST_TRUNCATED;
				end else begin
					bytes_left_nxt = data_byte;
					phase_nxt      = PH_SKIP;
				end
			end
			PH_SKIP: begin
				bytes_left_nxt = left_dec;
				if (left_dec == 8'd0) begin
					if (last_byte) begin
						emit    = 1'b1;
						emit_st = ST_NOT_FOUND;
					end else begin
						phase_nxt = PH_CODE;
					end
				end else if (last_byte) begin
					emit    = 1'b1;
					emit_st = ST_TRUNCATED;
				end
			end
			PH_CAPTURE: begin
				captured_nxt   = cap_shift;
				cnt_nxt        = cnt_inc;
				bytes_left_nxt = left_dec;
				if (left_dec == 8'd0 || last_byte) begin
					emit     = 1'b1;
					emit_st  = (left_dec == 8'd0) ? ST_FOUND : ST_TRUNCATED;
					emit_val = cap_shift;
					emit_cnt = cnt_inc;
				end
			end
			PH_DONE: begin
				if (last_byte) begin
					phase_nxt      = PH_CODE;
					bytes_left_nxt = '0;
					captured_nxt   = '0;
					cnt_nxt        = '0;
				end
			end
			default: begin
				phase_nxt = PH_CODE;
			end
		endcase

		// A decided result clears the entry state and, unless its byte is the last, waits for the last byte.
		if (emit) begin
			bytes_left_nxt = '0;
			captured_nxt   = '0;
			cnt_nxt        = '0;
			phase_nxt      = last_byte ? PH_CODE : PH_DONE;
		end

		res.emit         = emit;
		res.status       = emit_st;
		res.value_bytes  = emit_val;
		res.value_length = 3'(emit_cnt);
	end

endmodule

FILE: rtl/relay_agent_suboption_finder.sv
// Top level of the relay-agent suboption finder: input stage, state and result register.
//
//   Channel   Signals                                      Direction
//   input     in_valid, in_ready, data_byte, last_byte     into the block
//   result    out_valid, out_ready, status, value_bytes,   out of the block
//             value_length
//   config    wanted_code_we, wanted_code_wdata            into the block
//
// A byte is first registered in the input stage; from there the per-byte update moves
// the parse state and, when an option is decided, loads the result register, as soon as
// that stage advances. One byte is taken in every cycle while the result side keeps up.
// Reset puts the parser at the code byte of a new option, wanted_code back to the
// remote ID, and empties both the input stage and the result register.
// A stalled result holds the input stage, which in turn drops in_ready.
module relay_agent_suboption_finder import rasf_pkg::*; #(
	parameter int MAX_VALUE_BYTES = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wanted_code_we,
	input  logic [7:0]        wanted_code_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [ValueW-1:0] value_bytes,
	output logic [2:0]        value_length
);

	localparam int CntW = $clog2(MAX_VALUE_BYTES + 1);

	// Configuration register.
	logic [7:0] wanted_code_q;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parse state.
	phase_t            phase_q;
	logic [7:0]        bytes_left_q;
	logic [ValueW-1:0] captured_q;
	logic [CntW-1:0]   cnt_q;

	// Result register.
	logic              out_valid_q;
	status_t           status_q;
	logic [ValueW-1:0] value_q;
	logic [2:0]        length_q;

	phase_t            phase_nxt;
	logic [7:0]        bytes_left_nxt;
	logic [ValueW-1:0] captured_nxt;
	logic [CntW-1:0]   cnt_nxt;
	result_t           res;
	logic              advance;

	// The input stage moves on when the result register is empty or being drained,
	// since the byte in it may decide a result.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	rasf_step #(
		.MAX_VALUE_BYTES(MAX_VALUE_BYTES)
	) u_step (
		.phase         (phase_q),
		.bytes_left    (bytes_left_q),
		.captured      (captured_q),
		.cnt           (cnt_q),
		.wanted_code   (wanted_code_q),
		.data_byte     (byte_s1),
		.last_byte     (last_s1),
		.phase_nxt     (phase_nxt),
		.bytes_left_nxt(bytes_left_nxt),
		.captured_nxt  (captured_nxt),
		.cnt_nxt       (cnt_nxt),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_code_q <= WANTED_CODE_RESET;
		end else if (wanted_code_we) begin
			wanted_code_q <= wanted_code_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the input stage; it needs no reset.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_CODE;
			bytes_left_q <= '0;
			captured_q   <= '0;
			cnt_q        <= '0;
		end else if (advance) begin
			phase_q      <= phase_nxt;
			bytes_left_q <= bytes_left_nxt;
			captured_q   <= captured_nxt;
			cnt_q        <= cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; loaded only with a decided result.
	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			status_q <= res.status;
			value_q  <= res.value_bytes;
			length_q <= res.value_length;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign value_bytes  = value_q;
	assign value_length = length_q;

endmodule

FILE: rtl/rasf_checker.sv
// Port-level checker of the suboption finder and its bind to the top level.
`include "assert_macros.svh"

module rasf_checker import rasf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        status,
	input logic [ValueW-1:0] value_bytes,
	input logic [2:0]        value_length
);

	// A held result keeps its valid and its contents.
	`RASF_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(value_bytes) && $stable(value_length))

	// Only a found or truncated result can carry value bytes.
	`RASF_ASSERT_SAME(a_value_only_on_capture, clk, arst_n, out_valid && status != ST_FOUND && status != ST_TRUNCATED, value_bytes == '0 && value_length == 3'd0)

	// A fresh result after an empty result register comes from a transaction that the
	// input side accepted before it.
	`RASF_ASSERT_SAME(a_result_has_source, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind relay_agent_suboption_finder rasf_checker u_rasf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.value_bytes (value_bytes),
	.value_length(value_length)
);
